>>> design/xyz_mean_centering_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coordinate mean centering block
// Shared helpers that check properties on clk, with rst_n low disabling them.
// ----------------------------------------------------------------------------
`ifndef XYZ_MEAN_CENTERING_DEFINES_SVH
`define XYZ_MEAN_CENTERING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XMC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XMC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/xyz_mc_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate mean centering package
// Sizes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package xyz_mc_pkg;

    localparam int MAX_ATOMS = 64;
    localparam int NUM_AXES  = 3;
    localparam int COORD_W   = 32;
    localparam int WORD_W    = NUM_AXES * COORD_W;
    localparam int IDX_W     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
    localparam int SUM_W     = COORD_W + IDX_W;
    localparam int STEP_W    = $clog2(SUM_W);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [CNT_W-1:0]   count_t;

    typedef struct packed {
        logic load_en;
        logic div_start;
        logic emit_en;
        logic clear_frame;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_acc;
        logic div_done;
        logic issue_done;
        logic pipe_empty;
    } ctrl_sts_t;

endpackage

>>> design/xyz_mean_centering.sv
// Coordinate mean centering: subtracts the centroid of a frame from its atoms.
// Input words on s_axis carry x, y, z in signed Q15.16, with s_axis_tlast on
// the final atom of a frame. Up to MAX_ATOMS (64) atoms are stored and summed;
// further atoms of the frame are dropped and the frame is marked.
// After the last atom the sums are divided by the count, rounded to nearest
// with ties away from zero, in a bit-serial divider. The store is then
// replayed through a two-stage read pipeline, one word per cycle while
// m_axis_tready is high; m_axis_tlast marks the last atom and m_axis_tuser
// marks a frame with drops. Input is taken one word per cycle while
// loading, and not at all from the last atom until the final result has
// been taken. If the receiver stalls, the pipeline holds and no word is
// lost. Reset returns the block to loading with empty sums.
// ----------------------------------------------------------------------------
// Coordinate mean centering top level
// Joins the frame controller and the datapath to the stream ports.
// ----------------------------------------------------------------------------
module xyz_mean_centering (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic [xyz_mc_pkg::WORD_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // cen_x [31:0], cen_y [63:32], cen_z [95:64]
    output logic [xyz_mc_pkg::WORD_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // overflowed [0]
    output logic                          m_axis_tuser
);

    xyz_mc_pkg::ctrl_cmd_t cmd;
    xyz_mc_pkg::ctrl_sts_t sts;

    xyz_mc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    xyz_mc_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.load_en;

endmodule

>>> design/xyz_mc_div.sv
// ----------------------------------------------------------------------------
// Centroid divider
// Three lanes of restoring division, one quotient bit per cycle, that divide
// the per-axis sums by the atom count with rounding to nearest, ties away.
// ----------------------------------------------------------------------------
module xyz_mc_div (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  xyz_mc_pkg::sum_t [xyz_mc_pkg::NUM_AXES-1:0]  sums,
    input  xyz_mc_pkg::count_t                           count,
    output logic                                         done,
    output xyz_mc_pkg::coord_t [xyz_mc_pkg::NUM_AXES-1:0] centroid
);

    logic                                                busy_reg, busy_next;
    logic                                                done_reg, done_next;
    logic [xyz_mc_pkg::STEP_W-1:0]                       step_reg, step_next;
    xyz_mc_pkg::count_t                                  divisor_reg, divisor_next;
    logic [xyz_mc_pkg::NUM_AXES-1:0]                     neg_reg, neg_next;
    xyz_mc_pkg::sum_t [xyz_mc_pkg::NUM_AXES-1:0]         quo_reg, quo_next;
    xyz_mc_pkg::count_t [xyz_mc_pkg::NUM_AXES-1:0]       rem_reg, rem_next;

    logic                                                last_step;

    assign last_step = (step_reg == xyz_mc_pkg::STEP_W'(xyz_mc_pkg::SUM_W - 1));

    always_comb
    begin
        logic [xyz_mc_pkg::CNT_W:0] trial;
        logic [xyz_mc_pkg::CNT_W:0] diff;
        xyz_mc_pkg::sum_t           mag;

        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        trial        = '0;
        diff         = '0;
        mag          = '0;

        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            divisor_next = count;
            for (int a = 0; a < xyz_mc_pkg::NUM_AXES; a++)
            begin
                neg_next[a] = sums[a][xyz_mc_pkg::SUM_W-1];
                mag         = neg_next[a] ? ('0 - sums[a]) : sums[a];
                // Adding half the divisor before truncation rounds the magnitude.
                quo_next[a] = mag + xyz_mc_pkg::SUM_W'(count >> 1);
                rem_next[a] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int a = 0; a < xyz_mc_pkg::NUM_AXES; a++)
            begin
                trial = {rem_reg[a], quo_reg[a][xyz_mc_pkg::SUM_W-1]};
                diff  = trial - {1'b0, divisor_reg};
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next[a] = diff[xyz_mc_pkg::CNT_W-1:0];
                    quo_next[a] = {quo_reg[a][xyz_mc_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[a] = trial[xyz_mc_pkg::CNT_W-1:0];
                    quo_next[a] = {quo_reg[a][xyz_mc_pkg::SUM_W-2:0], 1'b0};
                end
            end
            step_next = step_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
    end

    always_comb
    begin
        for (int a = 0; a < xyz_mc_pkg::NUM_AXES; a++)
        begin
            centroid[a] = neg_reg[a] ? ('0 - quo_reg[a][xyz_mc_pkg::COORD_W-1:0])
                                     : quo_reg[a][xyz_mc_pkg::COORD_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

>>> design/xyz_mc_ctrl.sv
// ----------------------------------------------------------------------------
// Frame controller
// Sequences loading a frame, dividing the sums and replaying the store.
// ----------------------------------------------------------------------------
`include "xyz_mean_centering_defines.svh"

module xyz_mc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xyz_mc_pkg::ctrl_sts_t sts,
    output xyz_mc_pkg::ctrl_cmd_t cmd
);

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_LOAD  = 2'd0;
    localparam logic [STATE_W-1:0] ST_START = 2'd1;
    localparam logic [STATE_W-1:0] ST_DIV   = 2'd2;
    localparam logic [STATE_W-1:0] ST_EMIT  = 2'd3;

    logic [STATE_W-1:0] state_reg, state_next;

    always_comb
    begin
        cmd.load_en     = (state_reg == ST_LOAD);
        // The sums include the last atom only from the cycle after it is taken.
        cmd.div_start   = (state_reg == ST_START);
        cmd.emit_en     = (state_reg == ST_EMIT);
        cmd.clear_frame = (state_reg == ST_EMIT) && sts.issue_done && sts.pipe_empty;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (sts.last_acc)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.issue_done && sts.pipe_empty)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `XMC_ASSERT_NXT(a_start_then_div, cmd.div_start, state_reg == ST_DIV, "divider start not followed by the wait state")
    `XMC_ASSERT_IMP(a_done_only_in_div, sts.div_done, state_reg == ST_DIV, "divider finished outside the wait state")

endmodule

>>> design/xyz_mc_dpath.sv
// ----------------------------------------------------------------------------
// Mean centering datapath
// Point store, per-axis sums, atom count and the replay pipeline that
// subtracts the centroid with saturation.
// ----------------------------------------------------------------------------
`include "xyz_mean_centering_defines.svh"

module xyz_mc_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  xyz_mc_pkg::ctrl_cmd_t             cmd,
    output xyz_mc_pkg::ctrl_sts_t             sts,
    input  logic                              s_axis_tvalid,
    input  logic [xyz_mc_pkg::WORD_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tready,
    output logic                              m_axis_tvalid,
    output logic [xyz_mc_pkg::WORD_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser
);

    function automatic xyz_mc_pkg::coord_t sat_sub(input xyz_mc_pkg::coord_t a,
                                                  input xyz_mc_pkg::coord_t b);
        logic [xyz_mc_pkg::COORD_W:0] d;
        d = {a[xyz_mc_pkg::COORD_W-1], a} - {b[xyz_mc_pkg::COORD_W-1], b};
        if (d[xyz_mc_pkg::COORD_W] != d[xyz_mc_pkg::COORD_W-1])
        begin
            return {d[xyz_mc_pkg::COORD_W], {(xyz_mc_pkg::COORD_W-1){~d[xyz_mc_pkg::COORD_W]}}};
        end
        return d[xyz_mc_pkg::COORD_W-1:0];
    endfunction

    logic [xyz_mc_pkg::WORD_W-1:0] point_store [xyz_mc_pkg::MAX_ATOMS];

    xyz_mc_pkg::sum_t [xyz_mc_pkg::NUM_AXES-1:0]   sum_reg, sum_next;
    xyz_mc_pkg::count_t                            cnt_reg, cnt_next;
    logic                                          drop_reg, drop_next;
    xyz_mc_pkg::count_t                            rd_idx_reg, rd_idx_next;
    logic                                          rd_valid_reg;
    logic                                          rd_last_reg;
    logic [xyz_mc_pkg::WORD_W-1:0]                 rd_data_reg;
    logic                                          out_valid_reg;
    logic                                          out_last_reg;
    logic [xyz_mc_pkg::WORD_W-1:0]                 out_data_reg;

    xyz_mc_pkg::coord_t [xyz_mc_pkg::NUM_AXES-1:0] centroid;
    logic                                          div_done;
    logic                                          acc;
    logic                                          room;
    logic                                          advance;
    logic                                          issue;

    assign acc     = s_axis_tvalid && cmd.load_en;
    assign room    = (cnt_reg < xyz_mc_pkg::CNT_W'(xyz_mc_pkg::MAX_ATOMS));
    assign advance = !out_valid_reg || m_axis_tready;
    assign issue   = cmd.emit_en && advance && (rd_idx_reg != cnt_reg);

    always_comb
    begin
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.clear_frame)
        begin
            sum_next    = '0;
            cnt_next    = '0;
            drop_next   = 1'b0;
            rd_idx_next = '0;
        end
        else
        begin
            if (acc && room)
            begin
                for (int a = 0; a < xyz_mc_pkg::NUM_AXES; a++)
                begin
                    sum_next[a] = sum_reg[a] + xyz_mc_pkg::SUM_W'(signed'(
                        s_axis_tdata[a*xyz_mc_pkg::COORD_W +: xyz_mc_pkg::COORD_W]));
                end
                cnt_next = cnt_reg + 1'b1;
            end
            else if (acc)
            begin
                drop_next = 1'b1;
            end
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
            rd_idx_reg <= rd_idx_next;
            if (advance)
            begin
                rd_valid_reg  <= issue;
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && room)
        begin
            point_store[cnt_reg[xyz_mc_pkg::IDX_W-1:0]] <= s_axis_tdata;
        end
        if (issue)
        begin
            rd_data_reg <= point_store[rd_idx_reg[xyz_mc_pkg::IDX_W-1:0]];
        end
    end

    // Both replay stages move together, so a stalled word holds them both.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_last_reg <= ((rd_idx_reg + 1'b1) == cnt_reg);
        end
        if (advance && rd_valid_reg)
        begin
            for (int a = 0; a < xyz_mc_pkg::NUM_AXES; a++)
            begin
                out_data_reg[a*xyz_mc_pkg::COORD_W +: xyz_mc_pkg::COORD_W] <= sat_sub(
                    rd_data_reg[a*xyz_mc_pkg::COORD_W +: xyz_mc_pkg::COORD_W], centroid[a]);
            end
            out_last_reg <= rd_last_reg;
        end
    end

    xyz_mc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .sums     (sum_reg),
        .count    (cnt_reg),
        .done     (div_done),
        .centroid (centroid)
    );

    always_comb
    begin
        sts.last_acc   = acc && s_axis_tlast;
        sts.div_done   = div_done;
        sts.issue_done = (rd_idx_reg == cnt_reg);
        sts.pipe_empty = !rd_valid_reg && !out_valid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = drop_reg;

    `XMC_ASSERT_IMP(a_idx_within_count, 1'b1, rd_idx_reg <= cnt_reg, "replay index beyond atom count")
    `XMC_ASSERT_IMP(a_load_when_drained, acc, !rd_valid_reg && !out_valid_reg, "word accepted while replay pipeline busy")
    `XMC_ASSERT_IMP(a_end_after_all_read, out_valid_reg && out_last_reg, rd_idx_reg == cnt_reg, "frame end shown before all atoms were read")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the coordinate mean centering block
// Streams frames of x, y, z atoms into the block and predicts the centered
// atoms of each frame: the centroid rounded to nearest with ties away from
// zero, saturated differences, and the drop mark for frames beyond the store.
// A directed set of small frames covers the rails, rounding ties and
// saturation. Random frames follow under several patterns of source gaps and
// sink stalls, including one long sink hold-off, with a full drain after each.
// ----------------------------------------------------------------------------
module tb;

    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        int x;
        int y;
        int z;
        bit is_last;
    } atom_t;

    typedef struct {
        int cx;
        int cy;
        int cz;
        bit frame_end;
        bit overflowed;
    } centered_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [xyz_mc_pkg::WORD_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [xyz_mc_pkg::WORD_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;

    // Stimulus and expectations.
    atom_t     atom_feed[$];
    centered_t centered_due[$];
    atom_t     next_atom;

    // Predictor copy of the frame state.
    int     store_x[xyz_mc_pkg::MAX_ATOMS];
    int     store_y[xyz_mc_pkg::MAX_ATOMS];
    int     store_z[xyz_mc_pkg::MAX_ATOMS];
    longint acc_x;
    longint acc_y;
    longint acc_z;
    int     stored_atoms;
    bit     dropped;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit failed = 1'b0;
    int idle_cycles = 0;

    int atoms_queued = 0;
    int atoms_in = 0;
    int results_out = 0;
    int frames_done = 0;
    int drop_frames = 0;
    int sat_fields = 0;

    xyz_mean_centering u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic int centroid_axis(longint sum, int n);
        longint mag;
        longint q;
        mag = (sum < 0) ? -sum : sum;
        q = (mag + n / 2) / n;
        return (sum < 0) ? int'(-q) : int'(q);
    endfunction

    function automatic int clamp_diff(int a, int c);
        longint d;
        d = longint'(a) - longint'(c);
        if (d > longint'(32'sh7FFF_FFFF))
        begin
            d = 32'sh7FFF_FFFF;
            sat_fields++;
        end
        else if (d < -longint'(64'sh8000_0000))
        begin
            d = -longint'(64'sh8000_0000);
            sat_fields++;
        end
        return int'(d);
    endfunction

    // Takes one accepted atom into the frame and, on the last atom, queues
    // the whole frame of centered atoms.
    task automatic absorb_atom(atom_t a);
        int        mx;
        int        my;
        int        mz;
        centered_t r;
        if (stored_atoms < xyz_mc_pkg::MAX_ATOMS)
        begin
            store_x[stored_atoms] = a.x;
            store_y[stored_atoms] = a.y;
            store_z[stored_atoms] = a.z;
            acc_x += a.x;
            acc_y += a.y;
            acc_z += a.z;
            stored_atoms++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (a.is_last)
        begin
            if (stored_atoms > 0)
            begin
                mx = centroid_axis(acc_x, stored_atoms);
                my = centroid_axis(acc_y, stored_atoms);
                mz = centroid_axis(acc_z, stored_atoms);
                for (int i = 0; i < stored_atoms; i++)
                begin
                    r.cx = clamp_diff(store_x[i], mx);
                    r.cy = clamp_diff(store_y[i], my);
                    r.cz = clamp_diff(store_z[i], mz);
                    r.frame_end = (i == stored_atoms - 1);
                    r.overflowed = dropped;
                    centered_due.push_back(r);
                end
            end
            frames_done++;
            if (dropped)
                drop_frames++;
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            stored_atoms = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic check_centered(logic [xyz_mc_pkg::WORD_W-1:0] data, logic fend, logic ovf);
        centered_t e;
        if (centered_due.size() == 0)
        begin
            $error("unexpected centered word %h (tlast %b, tuser %b)", data, fend, ovf);
            failed = 1'b1;
        end
        else
        begin
            e = centered_due.pop_front();
            if (data[31:0] !== e.cx)
            begin
                $error("cen_x mismatch: expected %0d, got %0d", e.cx, $signed(data[31:0]));
                failed = 1'b1;
            end
            if (data[63:32] !== e.cy)
            begin
                $error("cen_y mismatch: expected %0d, got %0d", e.cy, $signed(data[63:32]));
                failed = 1'b1;
            end
            if (data[95:64] !== e.cz)
            begin
                $error("cen_z mismatch: expected %0d, got %0d", e.cz, $signed(data[95:64]));
                failed = 1'b1;
            end
            if (fend !== e.frame_end)
            begin
                $error("frame_end mismatch: expected %0b, got %0b", e.frame_end, fend);
                failed = 1'b1;
            end
            if (ovf !== e.overflowed)
            begin
                $error("overflowed mismatch: expected %0b, got %0b", e.overflowed, ovf);
                failed = 1'b1;
            end
        end
    endtask

    // Handshakes are sampled at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_taken)
        begin
            next_atom.x = s_axis_tdata[31:0];
            next_atom.y = s_axis_tdata[63:32];
            next_atom.z = s_axis_tdata[95:64];
            next_atom.is_last = s_axis_tlast;
            absorb_atom(next_atom);
            atoms_in++;
        end
        if (out_taken)
        begin
            check_centered(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            results_out++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("xyz_mean_centering test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Source side: a word stays offered until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (atom_feed.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_atom = atom_feed.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {next_atom.z, next_atom.y, next_atom.x};
                s_axis_tlast <= next_atom.is_last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stalls, or one long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_reqs != hold_served)
        begin
            hold_served <= hold_reqs;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic push_atom(int x, int y, int z, bit is_last);
        atom_t a;
        a.x = x;
        a.y = y;
        a.z = z;
        a.is_last = is_last;
        atom_feed.push_back(a);
        atoms_queued++;
    endtask

    function automatic int rand_coord(int mode, int base);
        int pick;
        case (mode)
            0: return $urandom;
            1: return base + int'($urandom_range(1 << 20)) - (1 << 19);
            2:
            begin
                pick = $urandom_range(5);
                case (pick)
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $urandom;
                endcase
            end
            default: return int'($urandom_range(7)) - 3;
        endcase
    endfunction

    task automatic queue_frame(int n);
        int mode;
        int bx;
        int by;
        int bz;
        mode = $urandom_range(3);
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        for (int i = 0; i < n; i++)
            push_atom(rand_coord(mode, bx), rand_coord(mode, by), rand_coord(mode, bz),
                      i == n - 1);
    endtask

    // Mostly short frames, some medium, and now and then one near or past
    // the store depth.
    task automatic queue_random_frames(int budget);
        int used;
        int r;
        int n;
        used = 0;
        while (used < budget)
        begin
            r = $urandom_range(99);
            if (r < 70)
                n = $urandom_range(1, 8);
            else if (r < 94)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(60, 70);
            queue_frame(n);
            used += n;
        end
    endtask

    task automatic wait_drain();
        while (atom_feed.size() > 0 || atoms_in != atoms_queued || centered_due.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        stored_atoms = 0;
        dropped = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: rails, rounding ties and saturation.
        push_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b1);
        push_atom(32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1'b0);
        push_atom(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b1);
        push_atom(1, -1, 3, 1'b0);
        push_atom(0, 0, 0, 1'b1);
        push_atom(1, 2, -2, 1'b0);
        push_atom(1, 0, 0, 1'b0);
        push_atom(0, 0, 0, 1'b1);
        for (int i = 0; i < 4; i++)
            push_atom(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, i == 3);
        for (int i = 0; i < 4; i++)
            push_atom((i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA,
                      (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555,
                      (i < 2) ? 32'h7FFF_FFFF : 32'h8000_0000, i == 3);
        push_atom(-2, 5, 32'sh7FFF_FFFF, 1'b0);
        push_atom(-1, 5, 32'sh7FFF_FFFF, 1'b0);
        push_atom(-1, 6, 32'sh8000_0000, 1'b0);
        push_atom(0, 6, 32'sh8000_0000, 1'b1);
        wait_drain();

        // No idling; a full store, a dropped last atom, and a long sink hold.
        queue_frame(xyz_mc_pkg::MAX_ATOMS);
        queue_frame(xyz_mc_pkg::MAX_ATOMS + 1);
        queue_random_frames(40);
        hold_reqs++;
        wait_drain();

        src_idle_pct = 76;
        queue_random_frames(90);
        wait_drain();

        src_idle_pct = 0;
        snk_stall_pct = 76;
        queue_random_frames(90);
        wait_drain();

        src_idle_pct = 29;
        snk_stall_pct = 29;
        queue_frame(xyz_mc_pkg::MAX_ATOMS + 6);
        queue_random_frames(60);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d frames (%0d with dropped atoms): %0d atoms in, %0d centered out,",
                 frames_done, drop_frames, atoms_in, results_out);
        $display("with %0d saturated fields, under four patterns of gaps and stalls.",
                 sat_fields);
        if (!failed)
            $display("xyz_mean_centering test passed");
        else
            $display("xyz_mean_centering test failed");
        $finish;
    end

endmodule
